// ===== hdl/in_order_completion_ring_top_assert.svh =====
// assertion macros used by the completion ring controller
// no dependencies
`ifndef IN_ORDER_COMPLETION_RING_TOP_ASSERT_SVH
`define IN_ORDER_COMPLETION_RING_TOP_ASSERT_SVH

// condition that holds at every clock out of reset
`define IOCR_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// condition that holds in the cycle after the trigger
`define IOCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/iocr_pkg.sv =====
// types, codes and constants of the in-order completion ring
// no dependencies
package iocr_pkg;

    localparam int MAX_SLOTS_DEF = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int NOTICE_W      = $clog2(MAX_RESULTS);

    localparam int QSIZE_W  = 6;
    localparam int LIMIT_W  = 10;
    localparam int RETRY_W  = 11;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 32;
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 5;

    localparam logic [QSIZE_W-1:0] QUEUE_SIZE_RST  = 6'd32;
    localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 10'd1000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 4;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_FLUSH    = 2'd2,
        OP_RELEASE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_GRANTED = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_NOTICE  = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_PENDING = 3'd4,
        KIND_FAILURE = 3'd5,
        KIND_ACK     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_RELEASE  = 2'd1,
        ST_FL_CHECK = 2'd2,
        ST_FL_EVAL  = 2'd3
    } state_t;

    typedef struct packed {
        op_t                        op;
        logic [SLOT_W-1:0]          slot;
        logic signed [STATUS_W-1:0] status;
        logic [TAG_W-1:0]           tag;
        logic [COUNT_W-1:0]         count;
    } cmd_t;

    typedef struct packed {
        kind_t                      kind;
        logic [SLOT_W-1:0]          slot;
        logic [TAG_W-1:0]           tag;
        logic signed [STATUS_W-1:0] status;
        logic                       warn;
        logic                       last;
    } result_t;

endpackage

// ===== hdl/in_order_completion_ring_top.sv =====
// in-order completion ring, top level with stream and register ports
// depends on iocr_pkg, iocr_ctrl, iocr_out_reg
//
// usage:
// requests enter on the s_ stream, operation in s_tuser; results leave on the
// m_ stream, kind and timeout warning in m_tuser, m_tlast on the final result
// of each request. registers are written on the cfg channel (index 0 queue
// size, index 1 retry limit), cfg_ready is always high; write only when idle.
// allocate and complete are handled while idle; the result is in the output
// register in the next cycle. release: the count is reduced by the ring size
// while it is at least the ring size, then the tail steps back and an ack
// is given once the output register is free. flush: the request is taken,
// then each visited entry gets a state ram read, then an evaluation; a walk
// reaching the tail adds flush done; each notice needs the output register free.
// a new request is taken only when the ring is idle and the output register
// is empty or being drained; a stalled receiver holds the walk at any entry that needs a result.
// reset: queue size 32, retry limit 1000, pointers, retry counter and done
// flags cleared; output stream empty. no clearing pass is needed.
module in_order_completion_ring_top #(
    parameter int MAX_SLOTS = iocr_pkg::MAX_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot[4:0], status_value[36:5], completion_tag[52:37], release_count[57:53]
    input  logic [iocr_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [iocr_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_slot[4:0], result_tag[20:5], result_status[52:21]
    output logic [iocr_pkg::M_TDATA_W-1:0]  m_tdata,
    // result_kind[2:0], timeout_warning[3]
    output logic [iocr_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [iocr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iocr_pkg::CFG_DATA_W-1:0] cfg_data
);

    iocr_pkg::cmd_t    cmd;
    iocr_pkg::result_t res;
    iocr_pkg::result_t res_out;
    logic              res_load;
    logic              res_ready;

    assign cmd.op     = iocr_pkg::op_t'(s_tuser[1:0]);
    assign cmd.slot   = s_tdata[4:0];
    assign cmd.status = s_tdata[36:5];
    assign cmd.tag    = s_tdata[52:37];
    assign cmd.count  = s_tdata[57:53];

    assign cfg_ready = 1'b1;

    iocr_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    iocr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (res),
        .can_load  (res_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_out)
    );

    assign m_tdata = {3'b000, res_out.status, res_out.tag, res_out.slot};
    assign m_tuser = {res_out.warn, res_out.kind};
    assign m_tlast = res_out.last;

endmodule

// ===== hdl/iocr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module iocr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/iocr_out_reg.sv =====
// result output register between the ring controller and the master stream
// depends on iocr_pkg
module iocr_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  iocr_pkg::result_t res_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output iocr_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    iocr_pkg::result_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

// ===== hdl/iocr_ctrl.sv =====
// ring controller: head/tail pointers, retry counter, flush walk sequencer
// depends on iocr_pkg, iocr_ram and in_order_completion_ring_top_assert.svh
`include "in_order_completion_ring_top_assert.svh"

module iocr_ctrl #(
    parameter int MAX_SLOTS = iocr_pkg::MAX_SLOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  iocr_pkg::cmd_t                       cmd,
    input  logic                                 cfg_valid,
    input  logic [iocr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iocr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 res_ready,
    output logic                                 res_load,
    output iocr_pkg::result_t                    res
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int SZ_W  = ($clog2(MAX_SLOTS + 1) > iocr_pkg::QSIZE_W) ?
                           $clog2(MAX_SLOTS + 1) : iocr_pkg::QSIZE_W;
    localparam int ST_W  = iocr_pkg::STATUS_W + 1;

    iocr_pkg::state_t                  state_reg;
    iocr_pkg::state_t                  state_next;
    logic [iocr_pkg::QSIZE_W-1:0]      queue_size_reg;
    logic [iocr_pkg::QSIZE_W-1:0]      queue_size_next;
    logic [iocr_pkg::LIMIT_W-1:0]      retry_limit_reg;
    logic [iocr_pkg::LIMIT_W-1:0]      retry_limit_next;
    logic [IDX_W-1:0]                  head_reg;
    logic [IDX_W-1:0]                  head_next;
    logic [IDX_W-1:0]                  tail_reg;
    logic [IDX_W-1:0]                  tail_next;
    logic [iocr_pkg::RETRY_W-1:0]      retry_reg;
    logic [iocr_pkg::RETRY_W-1:0]      retry_next;
    logic [iocr_pkg::NOTICE_W-1:0]     notice_reg;
    logic [iocr_pkg::NOTICE_W-1:0]     notice_next;
    logic [iocr_pkg::COUNT_W-1:0]      rem_reg;
    logic [iocr_pkg::COUNT_W-1:0]      rem_next;
    logic [MAX_SLOTS-1:0]              vld_reg;
    logic [MAX_SLOTS-1:0]              vld_next;
    logic                              vld_rd_reg;

    logic                              st_we;
    logic [IDX_W-1:0]                  st_waddr;
    logic [ST_W-1:0]                   st_wdata;
    logic [ST_W-1:0]                   st_rdata;
    logic                              tag_we;
    logic [iocr_pkg::TAG_W-1:0]        tag_rdata;
    logic                              rd_en;

    logic [SZ_W-1:0]                   qs_ext;
    logic [SZ_W-1:0]                   ring_sz;
    logic                              acc;
    logic                              cfg_qs_wr;
    logic [SZ_W-1:0]                   tail_inc;
    logic [IDX_W-1:0]                  tail_wrap;
    logic [SZ_W-1:0]                   head_inc;
    logic [IDX_W-1:0]                  head_wrap;
    logic                              is_full;
    logic                              slot_in_ring;
    logic [SZ_W-1:0]                   rem_ext;
    logic [SZ_W-1:0]                   tail_ext;
    logic                              rem_big;
    logic [SZ_W-1:0]                   rel_tail;
    logic                              walk_end;
    logic                              ent_done;
    logic                              ent_fail;
    logic                              ent_tag;
    logic                              notice_cap;
    logic [iocr_pkg::RETRY_W-1:0]      retry_inc;
    logic                              retry_over;

    // ring size clamped to the legal range
    assign qs_ext  = SZ_W'(queue_size_reg);
    assign ring_sz = (qs_ext < SZ_W'(2)) ? SZ_W'(2) :
                     ((qs_ext > SZ_W'(MAX_SLOTS)) ? SZ_W'(MAX_SLOTS) : qs_ext);

    assign cmd_ready = (state_reg == iocr_pkg::ST_IDLE) && res_ready;
    assign acc       = cmd_valid && cmd_ready;
    assign cfg_qs_wr = cfg_valid && (cfg_index == iocr_pkg::REG_QUEUE_SIZE);

    assign tail_inc     = SZ_W'(tail_reg) + SZ_W'(1);
    assign tail_wrap    = (tail_inc >= ring_sz) ? '0 : IDX_W'(tail_inc);
    assign head_inc     = SZ_W'(head_reg) + SZ_W'(1);
    assign head_wrap    = (head_inc >= ring_sz) ? '0 : IDX_W'(head_inc);
    assign is_full      = (tail_wrap == head_reg);
    assign slot_in_ring = (SZ_W'(cmd.slot) < ring_sz);

    // release: reduce the count below the ring size, then step the tail back
    assign rem_ext  = SZ_W'(rem_reg);
    assign tail_ext = SZ_W'(tail_reg);
    assign rem_big  = (rem_ext >= ring_sz);
    assign rel_tail = (tail_ext >= rem_ext) ? (tail_ext - rem_ext) :
                      (tail_ext + (ring_sz - rem_ext));

    assign walk_end   = (head_reg == tail_reg);
    assign ent_done   = vld_rd_reg && st_rdata[ST_W-1];
    assign ent_fail   = (st_rdata[iocr_pkg::STATUS_W-1:0] != '0);
    assign ent_tag    = (tag_rdata != '0);
    assign notice_cap = (notice_reg == iocr_pkg::NOTICE_W'(iocr_pkg::MAX_RESULTS - 1));
    assign retry_inc  = retry_reg + iocr_pkg::RETRY_W'(1);
    assign retry_over = (retry_inc > iocr_pkg::RETRY_W'(retry_limit_reg));

    assign rd_en = (state_reg == iocr_pkg::ST_FL_CHECK) && !walk_end;

    iocr_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (st_rdata)
    );

    iocr_ram #(
        .WIDTH (iocr_pkg::TAG_W),
        .DEPTH (MAX_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tail_reg),
        .wdata (cmd.tag),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (tag_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iocr_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (cmd.op)
                        iocr_pkg::OP_FLUSH:   state_next = iocr_pkg::ST_FL_CHECK;
                        iocr_pkg::OP_RELEASE: state_next = iocr_pkg::ST_RELEASE;
                        default:              state_next = iocr_pkg::ST_IDLE;
                    endcase
                end
            end
            iocr_pkg::ST_RELEASE:
            begin
                if (!rem_big && res_ready)
                begin
                    state_next = iocr_pkg::ST_IDLE;
                end
            end
            iocr_pkg::ST_FL_CHECK:
            begin
                if (!walk_end)
                begin
                    state_next = iocr_pkg::ST_FL_EVAL;
                end
                else if (res_ready)
                begin
                    state_next = iocr_pkg::ST_IDLE;
                end
            end
            iocr_pkg::ST_FL_EVAL:
            begin
                priority if (!ent_done || ent_fail || (ent_tag && notice_cap))
                begin
                    if (res_ready)
                    begin
                        state_next = iocr_pkg::ST_IDLE;
                    end
                end
                else if (ent_tag)
                begin
                    if (res_ready)
                    begin
                        state_next = iocr_pkg::ST_FL_CHECK;
                    end
                end
                else
                begin
                    state_next = iocr_pkg::ST_FL_CHECK;
                end
            end
            default: state_next = iocr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        queue_size_next  = queue_size_reg;
        retry_limit_next = retry_limit_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        retry_next       = retry_reg;
        notice_next      = notice_reg;
        rem_next         = rem_reg;
        vld_next         = vld_reg;
        st_we            = 1'b0;
        st_waddr         = tail_reg;
        st_wdata         = '0;
        tag_we           = 1'b0;
        res_load         = 1'b0;
        res.kind         = iocr_pkg::KIND_ACK;
        res.slot         = '0;
        res.tag          = '0;
        res.status       = '0;
        res.warn         = 1'b0;
        res.last         = 1'b1;

        unique case (state_reg)
            iocr_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (cmd.op)
                        iocr_pkg::OP_ALLOC:
                        begin
                            res_load = 1'b1;
                            res.slot = iocr_pkg::SLOT_W'(tail_reg);
                            if (is_full)
                            begin
                                res.kind = iocr_pkg::KIND_FULL;
                            end
                            else
                            begin
                                res.kind  = iocr_pkg::KIND_GRANTED;
                                res.tag   = cmd.tag;
                                st_we     = 1'b1;
                                tag_we    = 1'b1;
                                tail_next = tail_wrap;
                            end
                        end
                        iocr_pkg::OP_COMPLETE:
                        begin
                            res_load   = 1'b1;
                            res.kind   = iocr_pkg::KIND_ACK;
                            res.slot   = cmd.slot;
                            res.status = cmd.status;
                            st_waddr   = IDX_W'(cmd.slot);
                            st_wdata   = {1'b1, cmd.status};
                            st_we      = slot_in_ring;
                        end
                        iocr_pkg::OP_RELEASE:
                        begin
                            rem_next = cmd.count;
                        end
                        iocr_pkg::OP_FLUSH:
                        begin
                            notice_next = '0;
                        end
                        default:
                        begin
                            notice_next = notice_reg;
                        end
                    endcase
                end
            end
            iocr_pkg::ST_RELEASE:
            begin
                if (rem_big)
                begin
                    rem_next = iocr_pkg::COUNT_W'(rem_ext - ring_sz);
                end
                else if (res_ready)
                begin
                    tail_next = IDX_W'(rel_tail);
                    res_load  = 1'b1;
                    res.kind  = iocr_pkg::KIND_ACK;
                    res.slot  = iocr_pkg::SLOT_W'(rel_tail);
                end
            end
            iocr_pkg::ST_FL_CHECK:
            begin
                if (walk_end && res_ready)
                begin
                    retry_next = '0;
                    res_load   = 1'b1;
                    res.kind   = iocr_pkg::KIND_DONE;
                    res.slot   = iocr_pkg::SLOT_W'(head_reg);
                end
            end
            iocr_pkg::ST_FL_EVAL:
            begin
                res.slot = iocr_pkg::SLOT_W'(head_reg);
                priority if (!ent_done)
                begin
                    if (res_ready)
                    begin
                        res_load   = 1'b1;
                        res.kind   = iocr_pkg::KIND_PENDING;
                        res.warn   = retry_over;
                        retry_next = retry_over ? '0 : retry_inc;
                    end
                end
                else if (ent_fail)
                begin
                    res_load   = res_ready;
                    res.kind   = iocr_pkg::KIND_FAILURE;
                    res.status = st_rdata[iocr_pkg::STATUS_W-1:0];
                end
                else if (ent_tag && notice_cap)
                begin
                    res_load = res_ready;
                    res.kind = iocr_pkg::KIND_PENDING;
                end
                else if (ent_tag)
                begin
                    if (res_ready)
                    begin
                        res_load    = 1'b1;
                        res.kind    = iocr_pkg::KIND_NOTICE;
                        res.tag     = tag_rdata;
                        res.last    = 1'b0;
                        notice_next = notice_reg + iocr_pkg::NOTICE_W'(1);
                        head_next   = head_wrap;
                    end
                end
                else
                begin
                    head_next = head_wrap;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase

        if (st_we)
        begin
            vld_next[st_waddr] = 1'b1;
        end

        // the user must write registers only while idle; the block itself does not enforce it
        if (cfg_qs_wr)
        begin
            queue_size_next = cfg_data[iocr_pkg::QSIZE_W-1:0];
            head_next       = '0;
            tail_next       = '0;
            retry_next      = '0;
        end
        if (cfg_valid && (cfg_index == iocr_pkg::REG_RETRY_LIMIT))
        begin
            retry_limit_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= iocr_pkg::ST_IDLE;
            queue_size_reg  <= iocr_pkg::QUEUE_SIZE_RST;
            retry_limit_reg <= iocr_pkg::RETRY_LIMIT_RST;
            head_reg        <= '0;
            tail_reg        <= '0;
            retry_reg       <= '0;
            notice_reg      <= '0;
            rem_reg         <= '0;
            vld_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            queue_size_reg  <= queue_size_next;
            retry_limit_reg <= retry_limit_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            retry_reg       <= retry_next;
            notice_reg      <= notice_next;
            rem_reg         <= rem_next;
            vld_reg         <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            vld_rd_reg <= vld_reg[head_reg];
        end
    end

    `IOCR_ASSERT_ALWAYS(a_head_in_ring, clk, rst_n, SZ_W'(head_reg) < ring_sz,
        "head outside ring")
    `IOCR_ASSERT_ALWAYS(a_tail_in_ring, clk, rst_n, SZ_W'(tail_reg) < ring_sz,
        "tail outside ring")
    `IOCR_ASSERT_NEXT(a_read_then_eval, clk, rst_n, rd_en,
        state_reg == iocr_pkg::ST_FL_EVAL, "entry read not followed by evaluation")
    `IOCR_ASSERT_NEXT(a_size_write_clears, clk, rst_n, cfg_qs_wr,
        (head_reg == '0) && (tail_reg == '0) && (retry_reg == '0),
        "size write did not clear pointers")

endmodule

// ===== tb/in_order_completion_ring_top_tb.sv =====
// self-checking testbench for the in-order completion ring top level
// depends on iocr_pkg and in_order_completion_ring_top; a predictor class
// tracks slots, pointers and retries and checks each result in order
`timescale 1ns / 1ps

module in_order_completion_ring_top_tb;

    class completion_ring_checker;
        int unsigned       size_reg;
        int unsigned       limit_reg;
        bit                done_bit[iocr_pkg::MAX_SLOTS_DEF];
        logic [31:0]       slot_status[iocr_pkg::MAX_SLOTS_DEF];
        logic [15:0]       slot_tag[iocr_pkg::MAX_SLOTS_DEF];
        bit                tag_set[iocr_pkg::MAX_SLOTS_DEF];
        int unsigned       head_idx;
        int unsigned       tail_idx;
        int unsigned       retries;
        iocr_pkg::result_t due_results[$];
        int unsigned       bad_results;

        function new();
            size_reg    = 32'(iocr_pkg::QUEUE_SIZE_RST);
            limit_reg   = 32'(iocr_pkg::RETRY_LIMIT_RST);
            head_idx    = 0;
            tail_idx    = 0;
            retries     = 0;
            bad_results = 0;
            foreach (done_bit[i])
            begin
                done_bit[i] = 1'b0;
                tag_set[i]  = 1'b0;
            end
        endfunction

        function int unsigned ring_sz();
            int unsigned s;
            s = size_reg;
            if (s < 2)
                s = 2;
            if (s > iocr_pkg::MAX_SLOTS_DEF)
                s = iocr_pkg::MAX_SLOTS_DEF;
            return s;
        endfunction

        function void apply_write(logic [iocr_pkg::CFG_IDX_W-1:0] idx,
                                  logic [iocr_pkg::CFG_DATA_W-1:0] val);
            if (idx == iocr_pkg::REG_QUEUE_SIZE)
            begin
                size_reg = 32'(val) & 63;
                head_idx = 0;
                tail_idx = 0;
                retries  = 0;
            end
            else if (idx == iocr_pkg::REG_RETRY_LIMIT)
                limit_reg = 32'(val);
        endfunction

        function void add_due(iocr_pkg::kind_t k, int unsigned s, logic [15:0] t,
                              logic [31:0] st, bit w, bit l);
            iocr_pkg::result_t r;
            r.kind   = k;
            r.slot   = s[iocr_pkg::SLOT_W-1:0];
            r.tag    = t;
            r.status = st;
            r.warn   = w;
            r.last   = l;
            due_results.push_back(r);
        endfunction

        // a walk must never read the tag of a slot that was never allocated
        function bit flush_safe();
            int unsigned i;
            i = head_idx;
            while (i != tail_idx)
            begin
                if (!done_bit[i] || slot_status[i] != 0)
                    return 1'b1;
                if (!tag_set[i])
                    return 1'b0;
                i++;
                if (i >= ring_sz())
                    i = 0;
            end
            return 1'b1;
        endfunction

        function void note_request(iocr_pkg::cmd_t c);
            int unsigned sz;
            int unsigned nxt;
            int unsigned i;
            int          k;
            bit          w;
            sz = ring_sz();
            unique case (c.op)
                iocr_pkg::OP_ALLOC:
                begin
                    nxt = tail_idx + 1;
                    if (nxt >= sz)
                        nxt = 0;
                    if (nxt == head_idx)
                        add_due(iocr_pkg::KIND_FULL, tail_idx, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        done_bit[tail_idx]    = 1'b0;
                        slot_status[tail_idx] = '0;
                        slot_tag[tail_idx]    = c.tag;
                        tag_set[tail_idx]     = 1'b1;
                        add_due(iocr_pkg::KIND_GRANTED, tail_idx, c.tag, '0, 1'b0, 1'b1);
                        tail_idx = nxt;
                    end
                end
                iocr_pkg::OP_COMPLETE:
                begin
                    if (32'(c.slot) < sz)
                    begin
                        slot_status[c.slot] = c.status;
                        done_bit[c.slot]    = 1'b1;
                    end
                    add_due(iocr_pkg::KIND_ACK, 32'(c.slot), '0, c.status, 1'b0, 1'b1);
                end
                iocr_pkg::OP_RELEASE:
                begin
                    tail_idx = (tail_idx + sz - (32'(c.count) % sz)) % sz;
                    add_due(iocr_pkg::KIND_ACK, tail_idx, '0, '0, 1'b0, 1'b1);
                end
                default:
                begin
                    k = 0;
                    i = head_idx;
                    while (i != tail_idx)
                    begin
                        if (!done_bit[i])
                        begin
                            w = 1'b0;
                            retries = (retries + 1) & 2047;
                            if (retries > limit_reg)
                            begin
                                retries = 0;
                                w = 1'b1;
                            end
                            add_due(iocr_pkg::KIND_PENDING, i, '0, '0, w, 1'b1);
                            return;
                        end
                        if (slot_status[i] != 0)
                        begin
                            add_due(iocr_pkg::KIND_FAILURE, i, '0, slot_status[i],
                                    1'b0, 1'b1);
                            return;
                        end
                        if (slot_tag[i] != 0)
                        begin
                            // notice budget used up
                            if (k >= iocr_pkg::MAX_RESULTS - 1)
                            begin
                                add_due(iocr_pkg::KIND_PENDING, i, '0, '0, 1'b0, 1'b1);
                                return;
                            end
                            add_due(iocr_pkg::KIND_NOTICE, i, slot_tag[i], '0, 1'b0, 1'b0);
                            k++;
                        end
                        i++;
                        if (i >= sz)
                            i = 0;
                        head_idx = i;
                    end
                    retries = 0;
                    add_due(iocr_pkg::KIND_DONE, head_idx, '0, '0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(iocr_pkg::result_t got);
            iocr_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: unexpected result kind %0d slot %0d", $time,
                             got.kind, got.slot);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot || got.tag !== want.tag ||
                got.status !== want.status || got.warn !== want.warn ||
                got.last !== want.last)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display({"%0t: mismatch expected kind %0d slot %0d tag %h status %h",
                              " warn %b last %b"},
                             $time, want.kind, want.slot, want.tag, want.status, want.warn,
                             want.last);
                    $display({"%0t:          actual   kind %0d slot %0d tag %h status %h",
                              " warn %b last %b"},
                             $time, got.kind, got.slot, got.tag, got.status, got.warn,
                             got.last);
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [iocr_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [iocr_pkg::S_TUSER_W-1:0]  s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [iocr_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [iocr_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [iocr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [iocr_pkg::CFG_DATA_W-1:0] cfg_data;

    completion_ring_checker sb;
    bit                     calm;
    int unsigned            phase_size[6]  = '{2, 32, 0, 63, 9, 17};
    int unsigned            phase_limit[6] = '{0, 1023, 3, 1000, 1, 2};

    in_order_completion_ring_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_request(iocr_pkg::cmd_t c);
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {6'd0, c.count, c.tag, c.status, c.slot};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(c);
        if (!calm && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_fields(iocr_pkg::op_t op, int unsigned slot, logic [31:0] status,
                               logic [15:0] tag, int unsigned count);
        iocr_pkg::cmd_t c;
        c.op     = op;
        c.slot   = slot[iocr_pkg::SLOT_W-1:0];
        c.status = status;
        c.tag    = tag;
        c.count  = count[iocr_pkg::COUNT_W-1:0];
        send_request(c);
    endtask

    // index and data are held until the write is taken
    task automatic cfg_write(logic [iocr_pkg::CFG_IDX_W-1:0] idx,
                             logic [iocr_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_write(idx, val);
    endtask

    task automatic configure(int unsigned qsize, int unsigned limit);
        cfg_write(iocr_pkg::REG_QUEUE_SIZE, qsize[iocr_pkg::CFG_DATA_W-1:0]);
        cfg_write(iocr_pkg::REG_RETRY_LIMIT, limit[iocr_pkg::CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic iocr_pkg::cmd_t pick_request();
        iocr_pkg::cmd_t c;
        int unsigned    sz;
        int unsigned    used;
        int unsigned    r;
        int unsigned    off;
        sz       = sb.ring_sz();
        used     = (sb.tail_idx + sz - sb.head_idx) % sz;
        c.slot   = iocr_pkg::SLOT_W'($urandom);
        c.status = $urandom;
        c.tag    = iocr_pkg::TAG_W'($urandom);
        c.count  = iocr_pkg::COUNT_W'($urandom);
        r        = $urandom_range(99);
        if (r < 8)
            c.op = iocr_pkg::op_t'(2'($urandom_range(3)));
        else if (r < 40)
            c.op = (used == sz - 1 && $urandom_range(1) == 1) ? iocr_pkg::OP_FLUSH :
                                                               iocr_pkg::OP_ALLOC;
        else if (r < 70)
            c.op = iocr_pkg::OP_COMPLETE;
        else if (r < 92)
            c.op = iocr_pkg::OP_FLUSH;
        else
            c.op = iocr_pkg::OP_RELEASE;
        if (r >= 8)
        begin
            unique case (c.op)
                iocr_pkg::OP_ALLOC:
                    if ($urandom_range(4) == 0)
                        c.tag = '0;
                iocr_pkg::OP_COMPLETE:
                begin
                    // mostly outstanding slots, mostly success
                    if (used != 0 && $urandom_range(9) != 0)
                    begin
                        off    = $urandom_range(used - 1);
                        c.slot = iocr_pkg::SLOT_W'((sb.head_idx + off) % sz);
                    end
                    if ($urandom_range(99) < 85)
                        c.status = '0;
                end
                iocr_pkg::OP_RELEASE:
                    if ($urandom_range(3) != 0)
                        c.count = iocr_pkg::COUNT_W'($urandom_range(used));
                default:
                    ;
            endcase
        end
        if (c.op == iocr_pkg::OP_FLUSH && !sb.flush_safe())
            c.op = iocr_pkg::OP_ALLOC;
        return c;
    endfunction

    // receiver with random stalls and one long hold-off
    initial
    begin
        iocr_pkg::result_t got;
        int unsigned       seen;
        int unsigned       hold_left;
        bit                held;
        m_tready  = 1'b0;
        seen      = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind   = iocr_pkg::kind_t'(m_tuser[2:0]);
                got.slot   = m_tdata[4:0];
                got.tag    = m_tdata[20:5];
                got.status = m_tdata[52:21];
                got.warn   = m_tuser[3];
                got.last   = m_tlast;
                sb.check_result(got);
                seen++;
            end
            // hold off while the sender is offering requests
            if (!held && seen >= 200 && s_tvalid)
            begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three-slot ring, warning on the second pending flush
        configure(3, 1);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_ALLOC, 0, 0, 16'hFFFF, 0);
        send_fields(iocr_pkg::OP_ALLOC, 0, 0, 16'h0000, 0);
        send_fields(iocr_pkg::OP_ALLOC, 0, 0, 16'h1234, 0);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_COMPLETE, 1, 32'h0000_0000, 0, 0);
        send_fields(iocr_pkg::OP_COMPLETE, 0, 32'hFFFF_FFFF, 0, 0);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_COMPLETE, 0, 32'h0000_0000, 0, 0);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        // slot outside the ring
        send_fields(iocr_pkg::OP_COMPLETE, 31, 32'h7FFF_FFFF, 16'hFFFF, 31);
        send_fields(iocr_pkg::OP_COMPLETE, 2, 32'h8000_0000, 0, 0);
        // tail moved back past the head
        send_fields(iocr_pkg::OP_RELEASE, 31, 32'hFFFF_FFFF, 16'hFFFF, 31);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_RELEASE, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_RELEASE, 0, 0, 0, 2);
        send_fields(iocr_pkg::OP_ALLOC, 0, 0, 16'h8000, 0);
        send_fields(iocr_pkg::OP_COMPLETE, 2, 32'h0000_0000, 0, 0);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        send_fields(iocr_pkg::OP_RELEASE, 0, 0, 0, 5);
        send_fields(iocr_pkg::OP_FLUSH, 0, 0, 0, 0);
        s_tvalid <= 1'b0;

        for (int p = 0; p < 6; p++)
        begin
            drain();
            configure(phase_size[p], phase_limit[p]);
            calm = (p == 1);
            for (int n = 0; n < 60; n++)
                send_request(pick_request());
            s_tvalid <= 1'b0;
        end
        calm = 1'b0;
        drain();

        if (sb.bad_results == 0 && sb.due_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/iocr_pkg.sv
hdl/iocr_ram.sv
hdl/iocr_out_reg.sv
hdl/iocr_ctrl.sv
hdl/in_order_completion_ring_top.sv
tb/in_order_completion_ring_top_tb.sv
